### src/json_string_escaper_core_assert.svh
// Assertion macros for the JSON string escaper RTL.
`ifndef JSON_STRING_ESCAPER_CORE_ASSERT_SVH
`define JSON_STRING_ESCAPER_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
package jse_pkg;

   // Depth of the queue between the classifier and the emitter.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Character codes used by the classifier and the emitter.
   localparam logic [7:0] CHAR_LT        = 8'h3C;
   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;

   // How a byte is rendered: as itself, as a backslash pair, or as a \u00xx escape.
   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_PAIR,
      KIND_UNI
   } kind_type;

   // One classified item. For a pair, data is the byte after the backslash;
   // otherwise it is the original byte.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } item_type;

   // Transfer from the classifier into the queue.
   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   // Head of the queue as seen by the emitter.
   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   // Queue status.
   typedef struct packed {
      logic             full;
      logic [CNT_W-1:0] count;
   } qstat_type;

endpackage

### src/json_string_escaper_core.sv
// Top level of the JSON string escaper.
// Escapes a byte stream for use inside a JSON string literal, without the quotes.
// Each input byte yields a run of output bytes whose final byte carries run_last:
// plain bytes yield one output byte, quote, backslash, the short control escapes
// and a slash after '<' yield two, and other control bytes yield six (\u00xx).
// The emitter sends one byte per cycle while the output is not stalled, so output
// bandwidth is the limit: plain text then streams at one byte per cycle, and a
// four-entry queue between the classifier and the emitter keeps taking input while
// an escape run drains. The first byte of a run is written into the queue storage
// and then into the output register before it is presented on the output.
`include "json_string_escaper_core_assert.svh"

module json_string_escaper_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   jse_pkg::push_type  push;
   jse_pkg::head_type  head;
   jse_pkg::qstat_type qstat;
   logic               pop;
   logic               mid_run;

   // Classifier.
   jse_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .qstat          (qstat),
      .push           (push)
   );

   // Queue between the two sides.
   jse_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .qstat (qstat)
   );

   // Emitter.
   jse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   // A transfer that is not the last byte of its run.
   assign mid_run = rsp_valid && !rsp_stall && !rsp_run_last;

   // The emitter only retires an item that is present.
   `JSE_ASSERT_NOW(a_pop_needs_head, pop, head.valid, "pop from an empty queue")
   // Head validity agrees with the queue occupancy.
   `JSE_ASSERT_NOW(a_head_matches_count, 1'b1, head.valid == |qstat.count, "bad head valid")
   // A run is never broken by a bubble once its bytes have started.
   `JSE_ASSERT_NEXT(a_run_continues, mid_run, rsp_valid, "bubble inside an escape run")

endmodule

### src/jse_front.sv
// Classifier: accepts input bytes, decides their escape form and tracks a pending '<'.
module jse_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_in_byte,
   input  logic                req_string_end,
   input  jse_pkg::qstat_type  qstat,
   output jse_pkg::push_type   push
);

   logic slash_pending_ff;
   logic slash_pending_in;
   logic accept;

   // Map one byte to its escape form.
   function automatic jse_pkg::item_type classify(input logic [7:0] b, input logic pend);
      jse_pkg::item_type it;
      it.kind = jse_pkg::KIND_PLAIN;
      it.data = b;
      if (b == jse_pkg::CHAR_LT) begin
         it.kind = jse_pkg::KIND_PLAIN;
      end else if (b == jse_pkg::CHAR_SLASH && pend) begin
         it.kind = jse_pkg::KIND_PAIR;
      end else if (b == jse_pkg::CHAR_QUOTE || b == jse_pkg::CHAR_BACKSLASH) begin
         it.kind = jse_pkg::KIND_PAIR;
      end else if (b < 8'h20 || b == 8'h7F) begin
         it.kind = jse_pkg::KIND_PAIR;
         unique case (b)
            8'h08:   it.data = 8'h62;  // b
            8'h0C:   it.data = 8'h66;  // f
            8'h0A:   it.data = 8'h6E;  // n
            8'h0D:   it.data = 8'h72;  // r
            8'h09:   it.data = 8'h74;  // t
            default: it.kind = jse_pkg::KIND_UNI;
         endcase
      end
      return it;
   endfunction

   // A transfer is taken whenever the queue has room.
   assign req_stall = qstat.full;
   assign accept    = req_valid && !qstat.full;

   assign push.valid = accept;
   assign push.item  = classify(req_in_byte, slash_pending_ff);

   // The flag follows a '<' and clears at the end of each string.
   assign slash_pending_in = accept ? (!req_string_end && req_in_byte == jse_pkg::CHAR_LT)
                                    : slash_pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slash_pending_ff <= 1'b0;
      end else begin
         slash_pending_ff <= slash_pending_in;
      end
   end

endmodule

### src/jse_queue.sv
// Short queue of classified items between the classifier and the emitter.
module jse_queue (
   input  logic                clock,
   input  logic                reset,
   input  jse_pkg::push_type   push,
   input  logic                pop,
   output jse_pkg::head_type   head,
   output jse_pkg::qstat_type  qstat
);

   jse_pkg::item_type                 mem_ff [jse_pkg::QUEUE_DEPTH];
   logic [jse_pkg::PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [jse_pkg::PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [jse_pkg::CNT_W-1:0]         count_ff, count_in;

   assign qstat.full  = (count_ff == jse_pkg::CNT_W'(jse_pkg::QUEUE_DEPTH));
   assign qstat.count = count_ff;

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is payload only and needs no reset.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

### src/jse_back.sv
// Emitter: renders the head item one output byte per cycle while unstalled.
module jse_back (
   input  logic               clock,
   input  logic               reset,
   input  jse_pkg::head_type  head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_run_last
);

   logic [2:0] step_ff, step_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_out_byte_ff, rsp_out_byte_in;
   logic       rsp_run_last_ff, rsp_run_last_in;
   logic       out_free;
   logic       emit;
   logic [7:0] cur_byte;
   logic       cur_last;

   // Lowercase hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
   endfunction

   // Select the byte of the current escape sequence at this step.
   always_comb begin
      cur_byte = head.item.data;
      cur_last = 1'b1;
      unique case (head.item.kind)
         jse_pkg::KIND_PLAIN: begin
            cur_byte = head.item.data;
            cur_last = 1'b1;
         end
         jse_pkg::KIND_PAIR: begin
            cur_byte = (step_ff == 3'd0) ? jse_pkg::CHAR_BACKSLASH : head.item.data;
            cur_last = (step_ff != 3'd0);
         end
         jse_pkg::KIND_UNI: begin
            cur_last = (step_ff >= 3'd5);
            unique case (step_ff)
               3'd0:    cur_byte = jse_pkg::CHAR_BACKSLASH;
               3'd1:    cur_byte = jse_pkg::CHAR_U;
               3'd2:    cur_byte = jse_pkg::CHAR_ZERO;
               3'd3:    cur_byte = jse_pkg::CHAR_ZERO;
               3'd4:    cur_byte = hex_char(head.item.data[7:4]);
               default: cur_byte = hex_char(head.item.data[3:0]);
            endcase
         end
         default: begin
            cur_byte = head.item.data;
            cur_last = 1'b1;
         end
      endcase
   end

   // The output register advances when empty or when its transfer completes.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = head.valid && out_free;
   assign pop      = emit && cur_last;

   always_comb begin
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_out_byte_in = rsp_out_byte_ff;
      rsp_run_last_in = rsp_run_last_ff;
      if (out_free) begin
         rsp_valid_in    = head.valid;
         rsp_out_byte_in = cur_byte;
         rsp_run_last_in = cur_last;
      end
      if (emit) begin
         step_in = cur_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_run_last_ff <= rsp_run_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_run_last = rsp_run_last_ff;

endmodule

### dv/json_string_escaper_core_tb.sv
// Self-checking testbench for the JSON string escaper core.
module json_string_escaper_core_tb;

   // Control bytes with short escapes, the letters that name them, and other test bytes.
   localparam logic [7:0] CTRL_BACKSPACE = 8'h08;
   localparam logic [7:0] CTRL_TAB       = 8'h09;
   localparam logic [7:0] CTRL_NEWLINE   = 8'h0A;
   localparam logic [7:0] CTRL_FORMFEED  = 8'h0C;
   localparam logic [7:0] CTRL_RETURN    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;
   localparam logic [7:0] LETTER_B       = "b";
   localparam logic [7:0] LETTER_F       = "f";
   localparam logic [7:0] LETTER_N       = "n";
   localparam logic [7:0] LETTER_R       = "r";
   localparam logic [7:0] LETTER_T       = "t";
   localparam logic [7:0] LETTER_A       = "a";

   localparam int RANDOM_ITEMS = 345;
   localparam int HOLD_AT      = 100;  // accepted bytes before the long output hold
   localparam int LONG_HOLD    = 60;
   localparam int CALM_TAIL    = 40;   // final bytes sent with no idling
   localparam int WATCHDOG     = 500;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         drain_first;  // wait for all output before offering this byte
   } text_item_type;

   typedef struct {
      logic [7:0] text;
      logic       run_last;
   } escaped_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = CHAR_SPACE;
   logic       req_string_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;

   text_item_type    text_to_send [$];
   escaped_byte_type escaped_bytes [$];

   logic lt_seen = 1'b0;
   bit   req_fire = 1'b0;
   bit   rsp_fire = 1'b0;
   int   total_items = 0;
   int   taken_count = 0;
   int   output_count = 0;
   int   failures = 0;
   int   idle_cycles = 0;
   int   send_gap = 0;
   int   stall_left = 0;
   bit   long_hold_done = 1'b0;
   int   plain_count = 0;
   int   pair_count = 0;
   int   uni_count = 0;
   int   string_count = 0;
   logic calm;

   assign calm = (taken_count + CALM_TAIL >= total_items);

   json_string_escaper_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_string_end (req_string_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Lowercase hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) begin
         return jse_pkg::CHAR_ZERO + 8'(nibble);
      end
      return LETTER_A + 8'(nibble) - 8'd10;
   endfunction

   // Works out the escaped run for one input byte and queues it.
   function automatic void predict_escape(input logic [7:0] b, input logic fin);
      logic [7:0] seq [6];
      logic [7:0] letter;
      int         n;
      n = 0;
      case (b)
         CTRL_BACKSPACE: letter = LETTER_B;
         CTRL_FORMFEED:  letter = LETTER_F;
         CTRL_NEWLINE:   letter = LETTER_N;
         CTRL_RETURN:    letter = LETTER_R;
         CTRL_TAB:       letter = LETTER_T;
         default:        letter = 8'h00;
      endcase
      if (b == jse_pkg::CHAR_LT) begin
         seq[0] = b;
         n = 1;
      end else if (b == jse_pkg::CHAR_SLASH && lt_seen) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = jse_pkg::CHAR_SLASH;
         n = 2;
      end else if (b == jse_pkg::CHAR_QUOTE || b == jse_pkg::CHAR_BACKSLASH) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         seq[1] = b;
         n = 2;
      end else if (b < CHAR_SPACE || b == CHAR_DEL) begin
         seq[0] = jse_pkg::CHAR_BACKSLASH;
         if (letter != 8'h00) begin
            seq[1] = letter;
            n = 2;
         end else begin
            seq[1] = jse_pkg::CHAR_U;
            seq[2] = jse_pkg::CHAR_ZERO;
            seq[3] = jse_pkg::CHAR_ZERO;
            seq[4] = hex_char(b[7:4]);
            seq[5] = hex_char(b[3:0]);
            n = 6;
         end
      end else begin
         seq[0] = b;
         n = 1;
      end
      // The '<' flag survives only within a string.
      lt_seen = (b == jse_pkg::CHAR_LT) && !fin;
      if (n == 1) plain_count++;
      else if (n == 2) pair_count++;
      else uni_count++;
      if (fin) string_count++;
      for (int k = 0; k < n; k++) begin
         escaped_bytes.push_back('{text: seq[k], run_last: (k == n - 1)});
      end
   endfunction

   // Random string byte, weighted toward the bytes that need escaping.
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 11))
         0, 1:    return jse_pkg::CHAR_LT;
         2, 3:    return jse_pkg::CHAR_SLASH;
         4:       return $urandom_range(0, 1) ? jse_pkg::CHAR_QUOTE : jse_pkg::CHAR_BACKSLASH;
         5:       return 8'($urandom_range(CTRL_BACKSPACE, CTRL_RETURN));
         6:       return $urandom_range(0, 4) == 0 ? CHAR_DEL : 8'($urandom_range(1, 31));
         7:       return 8'($urandom_range(128, 255));
         default: return 8'($urandom_range(32, 126));
      endcase
   endfunction

   task automatic add_text(input logic [7:0] data, input logic last, input bit drain);
      text_to_send.push_back('{data: data, last: last, drain_first: drain});
   endtask

   // Stimulus and end of run.
   initial begin
      int len;
      int mode;
      int random_start;

      // Directed bytes: field extremes, every escape kind and the slash rules.
      add_text(LETTER_A, 1'b0, 1'b0);
      add_text(8'h01, 1'b0, 1'b0);
      add_text(8'h1F, 1'b0, 1'b0);
      add_text(CHAR_DEL, 1'b0, 1'b0);
      add_text(8'h80, 1'b0, 1'b0);
      add_text(8'hFF, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_QUOTE, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_BACKSLASH, 1'b0, 1'b0);
      add_text(CTRL_BACKSPACE, 1'b0, 1'b0);
      add_text(CTRL_FORMFEED, 1'b0, 1'b0);
      add_text(CTRL_NEWLINE, 1'b0, 1'b0);
      add_text(CTRL_RETURN, 1'b0, 1'b0);
      add_text(CTRL_TAB, 1'b0, 1'b0);
      // A slash with no '<' before it passes through.
      add_text(jse_pkg::CHAR_SLASH, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_LT, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_SLASH, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_LT, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_LT, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_SLASH, 1'b1, 1'b0);
      // The end of a string clears the '<' flag.
      add_text(jse_pkg::CHAR_LT, 1'b1, 1'b0);
      add_text(jse_pkg::CHAR_SLASH, 1'b0, 1'b0);
      // An escaped byte between '<' and '/' also clears it.
      add_text(jse_pkg::CHAR_LT, 1'b0, 1'b0);
      add_text(CTRL_NEWLINE, 1'b0, 1'b0);
      add_text(jse_pkg::CHAR_SLASH, 1'b1, 1'b0);
      add_text(CHAR_SPACE, 1'b1, 1'b0);

      // Random strings: mostly weighted text, some raw noise, some cut after '<'.
      random_start = text_to_send.size();
      while (text_to_send.size() < random_start + RANDOM_ITEMS) begin
         len = $urandom_range(1, 10);
         mode = $urandom_range(0, 7);
         for (int i = 0; i < len; i++) begin
            add_text(mode == 0 ? 8'($urandom_range(1, 255)) :
                     (mode == 1 && i == len - 1) ? jse_pkg::CHAR_LT : pick_text_byte(),
                     i == len - 1, 1'b0);
         end
      end
      // Let the pipeline empty out twice before a byte goes in.
      text_to_send[random_start].drain_first = 1'b1;
      text_to_send[random_start + RANDOM_ITEMS / 2].drain_first = 1'b1;
      total_items = text_to_send.size();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      wait (taken_count == total_items);
      wait (escaped_bytes.size() == 0);
      repeat (12) @(posedge clock);

      $display("Covered %0d bytes in %0d strings: %0d plain, %0d short, %0d \\u escapes,",
               taken_count, string_count, plain_count, pair_count, uni_count);
      $display("producing %0d output bytes under random stalls on both sides.", output_count);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Input driver: holds each byte until its transfer, idles in short bursts.
   always @(negedge clock) begin : send_text
      bit            offer;
      text_item_type cur;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offer = req_valid && !req_fire;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (text_to_send.size() > 0) begin
               if (text_to_send[0].drain_first && escaped_bytes.size() != 0) begin
                  // Waiting for the block to empty.
               end else if (!calm && $urandom_range(0, 5) == 0) begin
                  send_gap = $urandom_range(1, 5) - 1;
               end else begin
                  cur = text_to_send.pop_front();
                  offer = 1'b1;
                  req_in_byte <= cur.data;
                  req_string_end <= cur.last;
               end
            end
         end
         req_valid <= offer;
      end
   end

   // Output stall: random bursts plus one long hold while input keeps coming.
   always @(negedge clock) begin : stall_output
      bit stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall = 1'b0;
         if (stall_left > 0) begin
            stall_left--;
            stall = 1'b1;
         end else if (!long_hold_done && taken_count >= HOLD_AT) begin
            long_hold_done = 1'b1;
            stall_left = LONG_HOLD - 1;
            stall = 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            stall = 1'b1;
         end
         rsp_stall <= stall;
      end
   end

   // Monitor: predicts on each input transfer, checks each output transfer.
   always @(posedge clock) begin : check_output
      escaped_byte_type want;
      req_fire = !reset && req_valid && !req_stall;
      rsp_fire = !reset && rsp_valid && !rsp_stall;
      if (req_fire) begin
         predict_escape(req_in_byte, req_string_end);
         taken_count++;
      end
      if (rsp_fire) begin
         output_count++;
         if (escaped_bytes.size() == 0) begin
            $error("unexpected output byte %02h with nothing pending", rsp_out_byte);
            failures++;
         end else begin
            want = escaped_bytes.pop_front();
            if (rsp_out_byte !== want.text) begin
               $error("out_byte: expected %02h, got %02h", want.text, rsp_out_byte);
               failures++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_run_last);
               failures++;
            end
         end
      end
      // Watchdog on cycles without any transfer.
      if (req_fire || rsp_fire) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG) begin
         $display("Timeout: %0d cycles with no transfer, %0d bytes still expected.",
                  idle_cycles, escaped_bytes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
